// ----- hdl/bti_pkg.sv -----
package bti_pkg;

    localparam int ANGLE_W = 18;
    localparam int GRID_W  = 32;
    localparam int CFG_W   = 7;

    localparam logic [1:0] ACT_WR_AZ   = 2'd0;
    localparam logic [1:0] ACT_WR_EL   = 2'd1;
    localparam logic [1:0] ACT_WR_GRID = 2'd2;
    localparam logic [1:0] ACT_QUERY   = 2'd3;

    localparam logic REG_AZ_COUNT = 1'b0;
    localparam logic REG_EL_COUNT = 1'b1;

    // Full circle in signed Q4.13 radians.
    localparam logic signed [19:0] TWO_PI_Q = 20'sd51472;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 32;

    typedef logic signed [ANGLE_W:0] t_angle;

endpackage

// ----- hdl/bti_ram.sv -----
module bti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bilinear_table_interpolator_unit.sv -----
// Bilinear lookup over an elevation-by-azimuth intensity grid. Requests with action 0, 1 and 2
// write an azimuth breakpoint, an elevation breakpoint or a grid entry; a query request returns
// one result. A query first wraps the azimuth when the breakpoints span a full circle; then
// the breakpoint scan reads one entry of each breakpoint memory per cycle, the grid memory gives
// one corner per cycle, one shared 33 x 20 bit multiplier forms all products and the divider
// settles one quotient bit per cycle. A query with a zero count returns zero with no_data set.
// The block takes no new request while a query is under way; a finished result waits in the
// output register.
module bilinear_table_interpolator_unit #(
    parameter int MAX_AZIMUTH_POINTS   = 64,
    parameter int MAX_ELEVATION_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [bti_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // action, az_index, el_index, breakpoint_angle, grid_value, query_azimuth,
    // query_elevation, zero fill
    input  logic [bti_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // intensity
    output logic [bti_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // no_data
    output logic                                o_m_axis_tuser
);

    localparam int AIW = $clog2(MAX_AZIMUTH_POINTS);
    localparam int EIW = $clog2(MAX_ELEVATION_POINTS);
    localparam int NMX = (MAX_AZIMUTH_POINTS > MAX_ELEVATION_POINTS) ?
                         MAX_AZIMUTH_POINTS : MAX_ELEVATION_POINTS;
    localparam int NW  = $clog2(NMX + 1);
    localparam int GD  = MAX_AZIMUTH_POINTS * MAX_ELEVATION_POINTS;
    localparam int GW  = $clog2(GD);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ENDS  = 5'd1;
    localparam logic [4:0] S_ENDS2 = 5'd2;
    localparam logic [4:0] S_ENDS3 = 5'd3;
    localparam logic [4:0] S_WRAP0 = 5'd4;
    localparam logic [4:0] S_WRAP  = 5'd5;
    localparam logic [4:0] S_CLAMP = 5'd6;
    localparam logic [4:0] S_SRCH  = 5'd7;
    localparam logic [4:0] S_CELL  = 5'd8;
    localparam logic [4:0] S_CELL2 = 5'd9;
    localparam logic [4:0] S_CELL3 = 5'd10;
    localparam logic [4:0] S_GRID  = 5'd11;
    localparam logic [4:0] S_MUL   = 5'd12;
    localparam logic [4:0] S_CHK   = 5'd13;
    localparam logic [4:0] S_SAT   = 5'd14;
    localparam logic [4:0] S_DIV   = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0]               r_state;
    logic [bti_pkg::CFG_W-1:0] r_cfg_az;
    logic [bti_pkg::CFG_W-1:0] r_cfg_el;
    logic                     r_ovalid;
    logic [31:0]              r_res;
    logic                     r_nodata;
    logic [31:0]              r_odata;
    logic                     r_onodata;

    logic [NW-1:0]            r_na;
    logic [NW-1:0]            r_ne;
    bti_pkg::t_angle          r_a;
    bti_pkg::t_angle          r_e;
    bti_pkg::t_angle          r_front;
    bti_pkg::t_angle          r_back;
    bti_pkg::t_angle          r_el0;
    bti_pkg::t_angle          r_ell;
    logic signed [19:0]       r_d;
    logic [NW-1:0]            r_t;
    logic [NW-1:0]            r_ka;
    logic [NW-1:0]            r_ke;
    logic                     r_fa;
    logic                     r_fe;
    logic [AIW-1:0]           r_jlo;
    logic [AIW-1:0]           r_jup;
    logic [EIW-1:0]           r_ilo;
    logic [EIW-1:0]           r_iup;
    bti_pkg::t_angle          r_az1;
    bti_pkg::t_angle          r_az2;
    bti_pkg::t_angle          r_el1;
    bti_pkg::t_angle          r_el2;
    bti_pkg::t_angle          r_wa1;
    bti_pkg::t_angle          r_wa2;
    bti_pkg::t_angle          r_we1;
    bti_pkg::t_angle          r_we2;
    bti_pkg::t_angle          r_spa;
    bti_pkg::t_angle          r_spe;
    logic [2:0]               r_g;
    logic [31:0]              r_rv [4];
    logic [5:0]               r_s;
    logic signed [52:0]       r_prod;
    logic signed [37:0]       r_den;
    logic signed [52:0]       r_s1;
    logic signed [52:0]       r_s2;
    logic signed [79:0]       r_acc;
    logic [79:0]              r_num;
    logic [37:0]              r_dv;
    logic [37:0]              r_rem;
    logic [31:0]              r_ql;

    logic [1:0]               w_action;
    logic [5:0]               w_ai;
    logic [5:0]               w_ei;
    logic [17:0]              w_bp;
    logic [31:0]              w_gv;
    logic [17:0]              w_qa;
    logic [17:0]              w_qe;
    logic                     w_in_acc;
    logic                     w_oload;
    logic [NW-1:0]            w_na;
    logic [NW-1:0]            w_ne;
    logic [NW-1:0]            w_nmax;
    logic                     w_az_we;
    logic                     w_el_we;
    logic                     w_g_we;
    logic [AIW-1:0]           w_az_addr;
    logic [EIW-1:0]           w_el_addr;
    logic [GW-1:0]            w_g_addr;
    logic [17:0]              w_az_rd;
    logic [17:0]              w_el_rd;
    logic [31:0]              w_g_rd;
    bti_pkg::t_angle          w_az_rs;
    bti_pkg::t_angle          w_el_rs;
    logic [NW-1:0]            w_kac;
    logic [NW-1:0]            w_kec;
    logic [AIW-1:0]           w_jlo;
    logic [AIW-1:0]           w_jup;
    logic [EIW-1:0]           w_ilo;
    logic [EIW-1:0]           w_iup;
    logic [NW-1:0]            w_sidx;
    logic signed [32:0]       w_ma;
    logic signed [19:0]       w_mb;
    logic [38:0]              w_trial;
    logic                     w_ge;
    bti_pkg::t_angle          w_ca;
    bti_pkg::t_angle          w_ce;

    assign w_action = i_s_axis_tdata[1:0];
    assign w_ai     = i_s_axis_tdata[7:2];
    assign w_ei     = i_s_axis_tdata[13:8];
    assign w_bp     = i_s_axis_tdata[31:14];
    assign w_gv     = i_s_axis_tdata[63:32];
    assign w_qa     = i_s_axis_tdata[81:64];
    assign w_qe     = i_s_axis_tdata[99:82];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_oload         = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_onodata;

    assign w_na = (int'(r_cfg_az) > MAX_AZIMUTH_POINTS) ? NW'(MAX_AZIMUTH_POINTS) : NW'(r_cfg_az);
    assign w_ne = (int'(r_cfg_el) > MAX_ELEVATION_POINTS) ?
                  NW'(MAX_ELEVATION_POINTS) : NW'(r_cfg_el);
    assign w_nmax = (r_na > r_ne) ? r_na : r_ne;

    assign w_az_we = w_in_acc && (w_action == bti_pkg::ACT_WR_AZ) &&
                     (int'(w_ai) < MAX_AZIMUTH_POINTS);
    assign w_el_we = w_in_acc && (w_action == bti_pkg::ACT_WR_EL) &&
                     (int'(w_ei) < MAX_ELEVATION_POINTS);
    assign w_g_we  = w_in_acc && (w_action == bti_pkg::ACT_WR_GRID) &&
                     (int'(w_ai) < MAX_AZIMUTH_POINTS) && (int'(w_ei) < MAX_ELEVATION_POINTS);

    assign w_az_rs = bti_pkg::t_angle'(signed'(w_az_rd));
    assign w_el_rs = bti_pkg::t_angle'(signed'(w_el_rd));

    // Cell selection: the upper index is held within one and count minus one, the lower index one below it.
    always_comb begin
        w_kac = (r_ka > r_na - NW'(1)) ? r_na - NW'(1) : r_ka;
        if (w_kac == '0) begin
            w_kac = NW'(1);
        end
        w_kec = (r_ke > r_ne - NW'(1)) ? r_ne - NW'(1) : r_ke;
        if (w_kec == '0) begin
            w_kec = NW'(1);
        end
        w_jlo = (r_na == NW'(1)) ? '0 : AIW'(w_kac - NW'(1));
        w_jup = (r_na == NW'(1)) ? '0 : AIW'(w_kac);
        w_ilo = (r_ne == NW'(1)) ? '0 : EIW'(w_kec - NW'(1));
        w_iup = (r_ne == NW'(1)) ? '0 : EIW'(w_kec);
    end

    assign w_sidx = r_t - NW'(1);

    always_comb begin
        w_az_addr = '0;
        w_el_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                w_az_addr = AIW'(w_ai);
                w_el_addr = EIW'(w_ei);
            end
            S_ENDS2: begin
                w_az_addr = AIW'(r_na - NW'(1));
                w_el_addr = EIW'(r_ne - NW'(1));
            end
            S_SRCH: begin
                w_az_addr = AIW'(r_t);
                w_el_addr = EIW'(r_t);
            end
            S_CELL: begin
                w_az_addr = w_jlo;
                w_el_addr = w_ilo;
            end
            S_CELL2: begin
                w_az_addr = r_jup;
                w_el_addr = r_iup;
            end
            default: begin
                w_az_addr = '0;
                w_el_addr = '0;
            end
        endcase
    end

    always_comb begin
        if (r_state == S_IDLE) begin
            w_g_addr = GW'(int'(w_ei) * MAX_AZIMUTH_POINTS + int'(w_ai));
        end else begin
            unique case (r_g)
                3'd0:    w_g_addr = GW'(int'(r_ilo) * MAX_AZIMUTH_POINTS + int'(r_jlo));
                3'd1:    w_g_addr = GW'(int'(r_ilo) * MAX_AZIMUTH_POINTS + int'(r_jup));
                3'd2:    w_g_addr = GW'(int'(r_iup) * MAX_AZIMUTH_POINTS + int'(r_jlo));
                default: w_g_addr = GW'(int'(r_iup) * MAX_AZIMUTH_POINTS + int'(r_jup));
            endcase
        end
    end

    // Operand selection for the shared multiplier. The weighted sum is regrouped as
    // we2 * (r11 * wa2 + r12 * wa1) + we1 * (r21 * wa2 + r22 * wa1), each partial sum
    // being split into a low and a high part.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_s)
            6'd0: begin
                w_ma = 33'(r_spa);
                w_mb = 20'(r_spe);
            end
            6'd1: begin
                w_ma = signed'({1'b0, r_rv[0]});
                w_mb = 20'(r_wa2);
            end
            6'd2: begin
                w_ma = signed'({1'b0, r_rv[1]});
                w_mb = 20'(r_wa1);
            end
            6'd3: begin
                w_ma = signed'({1'b0, r_rv[2]});
                w_mb = 20'(r_wa2);
            end
            6'd4: begin
                w_ma = signed'({1'b0, r_rv[3]});
                w_mb = 20'(r_wa1);
            end
            6'd5: begin
                w_ma = signed'({7'b0, r_s1[25:0]});
                w_mb = 20'(r_we2);
            end
            6'd6: begin
                w_ma = 33'(signed'(r_s1[52:26]));
                w_mb = 20'(r_we2);
            end
            6'd7: begin
                w_ma = signed'({7'b0, r_s2[25:0]});
                w_mb = 20'(r_we1);
            end
            6'd8: begin
                w_ma = 33'(signed'(r_s2[52:26]));
                w_mb = 20'(r_we1);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_trial = {r_rem, r_ql[31]};
    assign w_ge    = (w_trial >= {1'b0, r_dv});

    assign w_ca = (r_a < r_front) ? r_front : r_a;
    assign w_ce = (r_e < r_el0) ? r_el0 : r_e;

    bti_ram #(.WIDTH(bti_pkg::ANGLE_W), .DEPTH(MAX_AZIMUTH_POINTS)) u_az_ram (
        .i_clk   (i_clk),
        .i_we    (w_az_we),
        .i_addr  (w_az_addr),
        .i_wdata (w_bp),
        .o_rdata (w_az_rd)
    );

    bti_ram #(.WIDTH(bti_pkg::ANGLE_W), .DEPTH(MAX_ELEVATION_POINTS)) u_el_ram (
        .i_clk   (i_clk),
        .i_we    (w_el_we),
        .i_addr  (w_el_addr),
        .i_wdata (w_bp),
        .o_rdata (w_el_rd)
    );

    bti_ram #(.WIDTH(bti_pkg::GRID_W), .DEPTH(GD)) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (w_g_we),
        .i_addr  (w_g_addr),
        .i_wdata (w_gv),
        .o_rdata (w_g_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg_az <= '0;
            r_cfg_el <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bti_pkg::REG_AZ_COUNT: r_cfg_az <= i_cfg_wdata;
                    default:               r_cfg_el <= i_cfg_wdata;
                endcase
            end
            if (w_oload) begin
                r_ovalid  <= 1'b1;
                r_odata   <= r_res;
                r_onodata <= r_nodata;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            r_prod <= w_ma * w_mb;

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (w_action == bti_pkg::ACT_QUERY)) begin
                        r_na <= w_na;
                        r_ne <= w_ne;
                        r_a  <= bti_pkg::t_angle'(signed'(w_qa));
                        r_e  <= bti_pkg::t_angle'(signed'(w_qe));
                        r_g  <= '0;
                        if ((w_na == '0) || (w_ne == '0)) begin
                            r_nodata <= 1'b1;
                            r_res    <= '0;
                            r_state  <= S_OUT;
                        end else begin
                            r_nodata <= 1'b0;
                            r_state  <= S_ENDS;
                        end
                    end
                end
                S_ENDS: begin
                    r_state <= S_ENDS2;
                end
                S_ENDS2: begin
                    r_front <= w_az_rs;
                    r_el0   <= w_el_rs;
                    r_state <= S_ENDS3;
                end
                S_ENDS3: begin
                    r_back  <= w_az_rs;
                    r_ell   <= w_el_rs;
                    r_state <= S_WRAP0;
                end
                S_WRAP0: begin
                    if (20'(r_back) - 20'(r_front) >= bti_pkg::TWO_PI_Q) begin
                        r_d     <= 20'(r_a) - 20'(r_front);
                        r_state <= S_WRAP;
                    end else begin
                        r_state <= S_CLAMP;
                    end
                end
                S_WRAP: begin
                    if (r_d < 0) begin
                        r_d <= r_d + bti_pkg::TWO_PI_Q;
                    end else if (r_d >= bti_pkg::TWO_PI_Q) begin
                        r_d <= r_d - bti_pkg::TWO_PI_Q;
                    end else begin
                        r_a     <= bti_pkg::t_angle'(20'(r_front) + r_d);
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_a     <= (w_ca > r_back) ? r_back : w_ca;
                    r_e     <= (w_ce > r_ell) ? r_ell : w_ce;
                    r_t     <= '0;
                    r_ka    <= r_na;
                    r_ke    <= r_ne;
                    r_fa    <= 1'b0;
                    r_fe    <= 1'b0;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_t != '0) begin
                        if (!r_fa && (w_sidx < r_na) && (w_az_rs >= r_a)) begin
                            r_ka <= w_sidx;
                            r_fa <= 1'b1;
                        end
                        if (!r_fe && (w_sidx < r_ne) && (w_el_rs >= r_e)) begin
                            r_ke <= w_sidx;
                            r_fe <= 1'b1;
                        end
                    end
                    if (r_t == w_nmax) begin
                        r_state <= S_CELL;
                    end else begin
                        r_t <= r_t + NW'(1);
                    end
                end
                S_CELL: begin
                    r_jlo   <= w_jlo;
                    r_jup   <= w_jup;
                    r_ilo   <= w_ilo;
                    r_iup   <= w_iup;
                    r_state <= S_CELL2;
                end
                S_CELL2: begin
                    r_az1   <= w_az_rs;
                    r_el1   <= w_el_rs;
                    r_state <= S_CELL3;
                end
                S_CELL3: begin
                    r_az2   <= w_az_rs;
                    r_el2   <= w_el_rs;
                    r_state <= S_GRID;
                end
                S_GRID: begin
                    r_wa2 <= r_az2 - r_a;
                    r_wa1 <= r_a - r_az1;
                    r_we2 <= r_el2 - r_e;
                    r_we1 <= r_e - r_el1;
                    r_spa <= r_az2 - r_az1;
                    r_spe <= r_el2 - r_el1;
                    if (r_g != '0) begin
                        r_rv[r_g[1:0] - 2'd1] <= w_g_rd;
                    end
                    if (r_g == 3'd4) begin
                        r_s     <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_g <= r_g + 3'd1;
                    end
                end
                S_MUL: begin
                    case (r_s)
                        6'd1: r_den <= r_prod[37:0];
                        6'd2: r_s1  <= r_prod;
                        6'd3: r_s1  <= r_s1 + r_prod;
                        6'd4: r_s2  <= r_prod;
                        6'd5: r_s2  <= r_s2 + r_prod;
                        6'd6: r_acc <= 80'(r_prod);
                        6'd7: r_acc <= r_acc + signed'({r_prod[52], r_prod, 26'b0});
                        6'd8: r_acc <= r_acc + 80'(r_prod);
                        6'd9: r_acc <= r_acc + signed'({r_prod[52], r_prod, 26'b0});
                        default: begin
                        end
                    endcase
                    if (r_s == 6'd9) begin
                        r_state <= S_CHK;
                    end else begin
                        r_s <= r_s + 6'd1;
                    end
                end
                S_CHK: begin
                    if (r_den == '0) begin
                        r_res   <= r_rv[0];
                        r_state <= S_OUT;
                    end else if ((r_acc == '0) || (r_acc[79] != r_den[37])) begin
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_num   <= r_acc[79] ? 80'(-r_acc) : 80'(r_acc);
                        r_dv    <= r_den[37] ? 38'(-r_den) : 38'(r_den);
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (r_num[79:32] >= {10'b0, r_dv}) begin
                        r_res   <= '1;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= r_num[69:32];
                        r_ql    <= r_num[31:0];
                        r_s     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? 38'(w_trial - {1'b0, r_dv}) : w_trial[37:0];
                    r_ql  <= {r_ql[30:0], w_ge};
                    if (r_s == 6'd31) begin
                        r_res   <= {r_ql[30:0], w_ge};
                        r_state <= S_OUT;
                    end else begin
                        r_s <= r_s + 6'd1;
                    end
                end
                S_OUT: begin
                    if (w_oload) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_nodata_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_action == bti_pkg::ACT_QUERY) && ((w_na == '0) || (w_ne == '0)))
        |=> ((r_state == S_OUT) && r_nodata))
        else $error("query with an empty table did not go straight to the output");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dv))
        else $error("divider remainder not below divisor");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_t <= w_nmax))
        else $error("breakpoint scan ran past the counts");
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("no-data result carries a nonzero intensity");
`endif

endmodule
